### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check c in the same cycle as a, outside reset.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Check c in the cycle after a, reset included.
`define ASSERT_NEXT(label, clk, a, c) \
    label: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### rtl/bpsad_pkg.sv
package bpsad_pkg;

    localparam int ACC_W     = 40;
    localparam int LEN_W     = 39;
    localparam int SHIFT_W   = 6;
    localparam int SHIFT_CAP = 42;
    localparam int DIGIT_STEP = 7;

    localparam logic [1:0] REG_SRC_LEN  = 2'd0;
    localparam logic [1:0] REG_TGT_SIZE = 2'd1;

    typedef enum logic [2:0] {
        CMD_SRC_READ = 3'd0,
        CMD_LITERAL  = 3'd1,
        CMD_SRC_COPY = 3'd2,
        CMD_TGT_COPY = 3'd3,
        CMD_STATUS   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SRC_READ = 3'd1,
        ERR_OFFSET   = 3'd2,
        ERR_SRC_LEN  = 3'd3,
        ERR_TRUNC    = 3'd4,
        ERR_SIZE     = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        ACT_SRC_READ = 2'd0,
        ACT_TGT_READ = 2'd1,
        ACT_SRC_COPY = 2'd2,
        ACT_TGT_COPY = 2'd3
    } t_action;

    // Add v << sh into the accumulator, saturating at all ones.
    function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] acc,
                                                 input logic [6:0] v,
                                                 input logic [SHIFT_W-1:0] sh);
        logic [ACC_W+7:0] t;
        logic [ACC_W+7:0] s;
        logic [ACC_W-1:0] r;
        t = {{(ACC_W+1){1'b0}}, v} << sh;
        s = t + {8'b0, acc};
        if (v == 7'd0) begin
            r = acc;
        end else if (sh > SHIFT_W'(ACC_W)) begin
            r = '1;
        end else if (|s[ACC_W+7:ACC_W]) begin
            r = '1;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/bps_patch_action_decoder_top.sv
// Channel   Direction  Handshake                   Payload
// patch in  input      i_in_valid / o_in_stall     i_patch_byte, i_stream_end
// result    output     o_out_valid / i_out_stall   o_command_kind .. o_finished
// config    input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_stall is low; results are decoded from the input register.
// The rate is set by the single decode step between the input and result registers.
// i_rst_n is synchronous: it clears the decode state, the config registers and both valids.
// A stalled result holds its register; the input register then fills and o_in_stall rises.
module bps_patch_action_decoder_top #(
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_patch_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_command_kind,
    output logic [31:0] o_from_address,
    output logic [31:0] o_to_address,
    output logic [32:0] o_copy_length,
    output logic [7:0]  o_literal_value,
    output logic [2:0]  o_error_code,
    output logic        o_finished
);
    import bpsad_pkg::*;

    localparam int POS_W = ADDR_BITS + 1;
    localparam int SUM_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam logic [SUM_W-1:0] POS_LIMIT = {{(SUM_W-1){1'b0}}, 1'b1} << ADDR_BITS;

    typedef enum logic [1:0] {
        PH_NUMBER  = 2'd0,
        PH_OFFSET  = 2'd1,
        PH_LITERAL = 2'd2
    } t_phase;

    function automatic logic fits(input logic [SUM_W-1:0] pos,
                                  input logic [SUM_W-1:0] len);
        return (pos + len) <= POS_LIMIT;
    endfunction

    logic [31:0]        r_source_length;
    logic [31:0]        r_expected_size;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_end;

    t_phase             r_phase,     n_phase;
    logic [ACC_W-1:0]   r_acc,       n_acc;
    logic [SHIFT_W-1:0] r_shift,     n_shift;
    logic               r_pend_tgt,  n_pend_tgt;
    logic [LEN_W-1:0]   r_pend_len,  n_pend_len;
    logic [LEN_W-1:0]   r_lit_rem,   n_lit_rem;
    logic [POS_W-1:0]   r_out_pos,   n_out_pos;
    logic [31:0]        r_src_off,   n_src_off;
    logic [POS_W-1:0]   r_tgt_off,   n_tgt_off;
    t_err               r_err,       n_err;

    logic               r_out_valid;
    t_cmd               r_kind;
    logic [31:0]        r_from;
    logic [31:0]        r_to;
    logic [32:0]        r_len;
    logic [7:0]         r_lit;
    t_err               r_err_out;
    logic               r_fin;

    logic               out_free;
    logic               proc;
    logic               emit;
    logic               have;
    t_cmd               res_kind;
    t_err               res_err;
    logic [SUM_W-1:0]   res_from;
    logic [SUM_W-1:0]   res_to;
    logic [LEN_W-1:0]   res_len;
    logic [7:0]         res_lit;

    logic               done;
    logic [ACC_W-1:0]   acc1;
    logic [ACC_W-1:0]   acc2;
    logic [SHIFT_W-1:0] shift_inc;
    logic [SHIFT_W-1:0] shift2;
    logic [LEN_W-1:0]   act_len;
    logic [LEN_W-1:0]   mag;
    logic               neg;
    logic [SUM_W-1:0]   pos_x;
    logic [SUM_W-1:0]   src_len_x;
    logic [SUM_W-1:0]   act_x;
    logic [SUM_W-1:0]   mag_x;
    logic [SUM_W-1:0]   pl_x;
    logic [SUM_W-1:0]   so_x;
    logic [SUM_W-1:0]   so_new_x;
    logic [SUM_W-1:0]   to_x;
    logic [SUM_W-1:0]   to_new_x;
    logic               src_fail;
    logic               tgt_fail;
    logic [SUM_W-1:0]   so_end_x;
    logic [SUM_W-1:0]   pos_pl_x;
    logic [SUM_W-1:0]   pos_act_x;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = !i_rst_n || (r_in_valid && !out_free);

    assign done      = r_in_byte[7];
    assign acc1      = acc_add(r_acc, r_in_byte[6:0], r_shift);
    assign shift_inc = r_shift + SHIFT_W'(DIGIT_STEP);
    assign shift2    = (shift_inc > SHIFT_W'(SHIFT_CAP)) ? SHIFT_W'(SHIFT_CAP) : shift_inc;
    assign acc2      = acc_add(acc1, 7'd1, shift2);

    assign act_len   = {1'b0, acc1[ACC_W-1:2]} + LEN_W'(1);
    assign mag       = acc1[ACC_W-1:1];
    assign neg       = acc1[0] && (|mag);

    assign pos_x     = SUM_W'(r_out_pos);
    assign src_len_x = SUM_W'(r_source_length);
    assign act_x     = SUM_W'(act_len);
    assign mag_x     = SUM_W'(mag);
    assign pl_x      = SUM_W'(r_pend_len);
    assign so_x      = SUM_W'(r_src_off);
    assign to_x      = SUM_W'(r_tgt_off);

    assign src_fail  = neg ? (mag_x > so_x) : ((so_x + mag_x) >= src_len_x);
    assign so_new_x  = neg ? (so_x - mag_x) : (so_x + mag_x);
    assign tgt_fail  = neg ? (mag_x > to_x) : ((to_x + mag_x) >= pos_x);
    assign to_new_x  = neg ? (to_x - mag_x) : (to_x + mag_x);
    assign so_end_x  = so_new_x + pl_x;
    assign pos_pl_x  = pos_x + pl_x;
    assign pos_act_x = pos_x + act_x;

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_shift    = r_shift;
        n_pend_tgt = r_pend_tgt;
        n_pend_len = r_pend_len;
        n_lit_rem  = r_lit_rem;
        n_out_pos  = r_out_pos;
        n_src_off  = r_src_off;
        n_tgt_off  = r_tgt_off;
        n_err      = r_err;
        have       = 1'b0;
        res_kind   = CMD_STATUS;
        res_from   = '0;
        res_to     = '0;
        res_len    = '0;
        res_lit    = '0;

        if (r_err == ERR_NONE) begin
            case (r_phase)
                PH_LITERAL: begin
                    have      = 1'b1;
                    res_kind  = CMD_LITERAL;
                    res_to    = pos_x;
                    res_len   = LEN_W'(1);
                    res_lit   = r_in_byte;
                    n_out_pos = r_out_pos + POS_W'(1);
                    n_lit_rem = r_lit_rem - LEN_W'(1);
                    if (r_lit_rem == LEN_W'(1)) begin
                        n_phase = PH_NUMBER;
                    end
                end
                PH_OFFSET: begin
                    if (done) begin
                        n_acc   = '0;
                        n_shift = '0;
                        n_phase = PH_NUMBER;
                        if (!r_pend_tgt) begin
                            if (src_fail) begin
                                n_err = ERR_OFFSET;
                            end else if (so_end_x > src_len_x) begin
                                n_err = ERR_SRC_LEN;
                            end else if (!fits(pos_x, pl_x)) begin
                                n_err = ERR_SIZE;
                            end else begin
                                have      = 1'b1;
                                res_kind  = CMD_SRC_COPY;
                                res_from  = so_new_x;
                                res_to    = pos_x;
                                res_len   = r_pend_len;
                                n_src_off = so_end_x[31:0];
                                n_out_pos = pos_pl_x[POS_W-1:0];
                            end
                        end else begin
                            if (tgt_fail) begin
                                n_err = ERR_OFFSET;
                            end else if (!fits(pos_x, pl_x)) begin
                                n_err = ERR_SIZE;
                            end else begin
                                have      = 1'b1;
                                res_kind  = CMD_TGT_COPY;
                                res_from  = to_new_x;
                                res_to    = pos_x;
                                res_len   = r_pend_len;
                                n_tgt_off = to_new_x[POS_W-1:0] + pl_x[POS_W-1:0];
                                n_out_pos = pos_pl_x[POS_W-1:0];
                            end
                        end
                    end else begin
                        n_acc   = acc2;
                        n_shift = shift2;
                    end
                end
                default: begin
                    n_phase = PH_NUMBER;
                    if (done) begin
                        n_acc   = '0;
                        n_shift = '0;
                        case (t_action'(acc1[1:0]))
                            ACT_SRC_READ: begin
                                if (pos_act_x > src_len_x) begin
                                    n_err = ERR_SRC_READ;
                                end else if (!fits(pos_x, act_x)) begin
                                    n_err = ERR_SIZE;
                                end else begin
                                    have      = 1'b1;
                                    res_kind  = CMD_SRC_READ;
                                    res_from  = pos_x;
                                    res_to    = pos_x;
                                    res_len   = act_len;
                                    n_out_pos = pos_act_x[POS_W-1:0];
                                end
                            end
                            ACT_TGT_READ: begin
                                if (!fits(pos_x, act_x)) begin
                                    n_err = ERR_SIZE;
                                end else begin
                                    n_lit_rem = act_len;
                                    n_phase   = PH_LITERAL;
                                end
                            end
                            default: begin
                                n_pend_tgt = acc1[0];
                                n_pend_len = act_len;
                                n_phase    = PH_OFFSET;
                            end
                        endcase
                    end else begin
                        n_acc   = acc2;
                        n_shift = shift2;
                    end
                end
            endcase

            if (r_in_end && n_err == ERR_NONE) begin
                if (n_phase != PH_NUMBER || n_shift != '0) begin
                    n_err = ERR_TRUNC;
                end else if (SUM_W'(n_out_pos) != SUM_W'(r_expected_size)) begin
                    n_err = ERR_SIZE;
                end
            end
        end

        res_err = n_err;
        emit    = have || r_in_end || (n_err != r_err);

        if (r_in_end) begin
            n_phase    = PH_NUMBER;
            n_acc      = '0;
            n_shift    = '0;
            n_pend_tgt = 1'b0;
            n_pend_len = '0;
            n_lit_rem  = '0;
            n_out_pos  = '0;
            n_src_off  = '0;
            n_tgt_off  = '0;
            n_err      = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_length <= '0;
            r_expected_size <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_NUMBER;
            r_acc           <= '0;
            r_shift         <= '0;
            r_pend_tgt      <= 1'b0;
            r_pend_len      <= '0;
            r_lit_rem       <= '0;
            r_out_pos       <= '0;
            r_src_off       <= '0;
            r_tgt_off       <= '0;
            r_err           <= ERR_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SRC_LEN:  r_source_length <= i_cfg_data;
                    REG_TGT_SIZE: r_expected_size <= i_cfg_data;
                    default: ;
                endcase
            end

            if (!r_in_valid || proc) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_patch_byte;
                r_in_end   <= i_stream_end;
            end

            if (proc) begin
                r_phase    <= n_phase;
                r_acc      <= n_acc;
                r_shift    <= n_shift;
                r_pend_tgt <= n_pend_tgt;
                r_pend_len <= n_pend_len;
                r_lit_rem  <= n_lit_rem;
                r_out_pos  <= n_out_pos;
                r_src_off  <= n_src_off;
                r_tgt_off  <= n_tgt_off;
                r_err      <= n_err;
            end

            if (out_free) begin
                r_out_valid <= proc && emit;
                r_kind      <= res_kind;
                r_from      <= res_from[31:0];
                r_to        <= res_to[31:0];
                r_len       <= res_len[32:0];
                r_lit       <= res_lit;
                r_err_out   <= res_err;
                r_fin       <= r_in_end;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_kind  = r_kind;
    assign o_from_address  = r_from;
    assign o_to_address    = r_to;
    assign o_copy_length   = r_len;
    assign o_literal_value = r_lit;
    assign o_error_code    = r_err_out;
    assign o_finished      = r_fin;

endmodule

### rtl/bpsad_checker.sv
`include "assert_macros.svh"

module bpsad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  i_command_kind,
    input logic [32:0] i_copy_length,
    input logic [31:0] i_from_address,
    input logic [2:0]  i_error_code,
    input logic        i_finished
);
    import bpsad_pkg::*;

    logic held;
    logic lit_ok;
    logic err_status;

    assign held       = i_out_valid && i_out_stall;
    assign lit_ok     = (i_command_kind != CMD_LITERAL) || (i_copy_length == 33'd1);
    assign err_status = (i_error_code == ERR_NONE) || i_finished
                        || (i_command_kind == CMD_STATUS);

    `ASSERT_NEXT(a_no_valid_after_reset, i_clk, !i_rst_n, !i_out_valid)
    `ASSERT_NEXT(a_stalled_kind_holds, i_clk, i_rst_n && held, i_command_kind == $past(i_command_kind))
    `ASSERT_SAME(a_literal_length, i_clk, i_rst_n, i_out_valid, lit_ok)
    `ASSERT_SAME(a_error_gives_status, i_clk, i_rst_n, i_out_valid, err_status)
    `ASSERT_SAME(a_status_no_addr, i_clk, i_rst_n, i_out_valid && i_command_kind == CMD_STATUS, i_from_address == '0 && i_copy_length == '0)

endmodule

bind bps_patch_action_decoder_top bpsad_checker u_bpsad_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_command_kind (o_command_kind),
    .i_copy_length  (o_copy_length),
    .i_from_address (o_from_address),
    .i_error_code   (o_error_code),
    .i_finished     (o_finished)
);

### test/bps_patch_action_decoder_top_tb.sv
module bps_patch_action_decoder_top_tb;
    import bpsad_pkg::*;

    localparam int ADDR_BITS = 32;
    localparam logic [63:0] ADDR_SPAN = 64'd1 << ADDR_BITS;
    localparam logic [63:0] ACC_FULL = (64'd1 << ACC_W) - 64'd1;
    localparam int TOTAL_REQS = 1650;
    localparam int NUM_SETTINGS = 7;

    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        t_cmd        kind;
        logic [31:0] from_addr;
        logic [31:0] to_addr;
        logic [32:0] length;
        logic [7:0]  literal;
        t_err        err;
        logic        finished;
    } t_result;

    class command_scoreboard;
        typedef enum logic [1:0] {
            DEC_ACTION,
            DEC_OFFSET,
            DEC_LITERAL
        } t_dec;

        logic [31:0]      src_len;
        logic [31:0]      tgt_size;
        t_dec             dec;
        logic [ACC_W-1:0] acc;
        int unsigned      digit_sh;
        t_action          pend_kind;
        logic [LEN_W-1:0] pend_len;
        logic [32:0]      lit_left;
        logic [32:0]      out_pos;
        logic [31:0]      src_off;
        logic [32:0]      tgt_off;
        t_err             err_latch;
        t_result          expected_cmds[$];
        int               failures;
        int               checked;
        int               error_ends;

        function new();
            src_len    = '0;
            tgt_size   = '0;
            failures   = 0;
            checked    = 0;
            error_ends = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            dec       = DEC_ACTION;
            acc       = '0;
            digit_sh  = 0;
            pend_kind = ACT_SRC_READ;
            pend_len  = '0;
            lit_left  = '0;
            out_pos   = '0;
            src_off   = '0;
            tgt_off   = '0;
            err_latch = ERR_NONE;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_SRC_LEN) begin
                src_len = data;
            end else if (idx == REG_TGT_SIZE) begin
                tgt_size = data;
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void raise_err(t_err code);
            if (err_latch == ERR_NONE) begin
                err_latch = code;
            end
        endfunction

        function void acc_plus(logic [6:0] v, int unsigned sh);
            logic [63:0] t;
            if (v == 7'd0) begin
                return;
            end
            if (sh > ACC_W) begin
                acc = '1;
                return;
            end
            t = 64'(v) << sh;
            if (t > ACC_FULL - 64'(acc)) begin
                acc = '1;
            end else begin
                acc = acc + t[ACC_W-1:0];
            end
        endfunction

        function bit take_digit(logic [7:0] b);
            acc_plus(b[6:0], digit_sh);
            if (b[7]) begin
                return 1'b1;
            end
            digit_sh += DIGIT_STEP;
            if (digit_sh > SHIFT_CAP) begin
                digit_sh = SHIFT_CAP;
            end
            acc_plus(7'd1, digit_sh);
            return 1'b0;
        endfunction

        function bit room_for(logic [63:0] len);
            return (64'(out_pos) <= ADDR_SPAN) && (len <= ADDR_SPAN - 64'(out_pos));
        endfunction

        function bit move_offset(inout logic [63:0] pos, input logic [63:0] mag,
                                 input bit neg, input logic [63:0] limit);
            if (neg) begin
                if (mag > pos) begin
                    return 1'b0;
                end
                pos = pos - mag;
            end else begin
                if (pos + mag >= limit) begin
                    return 1'b0;
                end
                pos = pos + mag;
            end
            return 1'b1;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            t_result     r;
            t_err        err_before;
            bit          have;
            bit          neg;
            logic [63:0] v;
            logic [63:0] mag;
            logic [63:0] len;
            logic [63:0] pos;
            err_before  = err_latch;
            have        = 1'b0;
            r.kind      = CMD_STATUS;
            r.from_addr = '0;
            r.to_addr   = '0;
            r.length    = '0;
            r.literal   = '0;
            r.err       = ERR_NONE;
            r.finished  = 1'b0;
            if (err_latch == ERR_NONE) begin
                case (dec)
                    DEC_LITERAL: begin
                        have      = 1'b1;
                        r.kind    = CMD_LITERAL;
                        r.to_addr = out_pos[31:0];
                        r.length  = 33'd1;
                        r.literal = b;
                        out_pos   = out_pos + 33'd1;
                        lit_left  = lit_left - 33'd1;
                        if (lit_left == '0) begin
                            dec = DEC_ACTION;
                        end
                    end
                    DEC_OFFSET: begin
                        if (take_digit(b)) begin
                            v        = 64'(acc);
                            mag      = v >> 1;
                            neg      = v[0] && (mag != 0);
                            acc      = '0;
                            digit_sh = 0;
                            dec      = DEC_ACTION;
                            if (pend_kind == ACT_SRC_COPY) begin
                                pos = 64'(src_off);
                                if (!move_offset(pos, mag, neg, 64'(src_len))) begin
                                    raise_err(ERR_OFFSET);
                                end else begin
                                    src_off = pos[31:0];
                                    if (pos + 64'(pend_len) > 64'(src_len)) begin
                                        raise_err(ERR_SRC_LEN);
                                    end else if (!room_for(64'(pend_len))) begin
                                        raise_err(ERR_SIZE);
                                    end else begin
                                        have        = 1'b1;
                                        r.kind      = CMD_SRC_COPY;
                                        r.from_addr = src_off;
                                        r.to_addr   = out_pos[31:0];
                                        r.length    = pend_len[32:0];
                                        src_off     = src_off + pend_len[31:0];
                                        out_pos     = out_pos + pend_len[32:0];
                                    end
                                end
                            end else begin
                                pos = 64'(tgt_off);
                                if (!move_offset(pos, mag, neg, 64'(out_pos))) begin
                                    raise_err(ERR_OFFSET);
                                end else begin
                                    tgt_off = pos[32:0];
                                    if (!room_for(64'(pend_len))) begin
                                        raise_err(ERR_SIZE);
                                    end else begin
                                        have        = 1'b1;
                                        r.kind      = CMD_TGT_COPY;
                                        r.from_addr = tgt_off[31:0];
                                        r.to_addr   = out_pos[31:0];
                                        r.length    = pend_len[32:0];
                                        tgt_off     = tgt_off + pend_len[32:0];
                                        out_pos     = out_pos + pend_len[32:0];
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        dec = DEC_ACTION;
                        if (take_digit(b)) begin
                            v        = 64'(acc);
                            len      = (v >> 2) + 64'd1;
                            acc      = '0;
                            digit_sh = 0;
                            case (t_action'(v[1:0]))
                                ACT_SRC_READ: begin
                                    if (64'(out_pos) + len > 64'(src_len)) begin
                                        raise_err(ERR_SRC_READ);
                                    end else if (!room_for(len)) begin
                                        raise_err(ERR_SIZE);
                                    end else begin
                                        have        = 1'b1;
                                        r.kind      = CMD_SRC_READ;
                                        r.from_addr = out_pos[31:0];
                                        r.to_addr   = out_pos[31:0];
                                        r.length    = len[32:0];
                                        out_pos     = out_pos + len[32:0];
                                    end
                                end
                                ACT_TGT_READ: begin
                                    if (!room_for(len)) begin
                                        raise_err(ERR_SIZE);
                                    end else begin
                                        lit_left = len[32:0];
                                        dec      = DEC_LITERAL;
                                    end
                                end
                                default: begin
                                    pend_kind = t_action'(v[1:0]);
                                    pend_len  = len[LEN_W-1:0];
                                    dec       = DEC_OFFSET;
                                end
                            endcase
                        end
                    end
                endcase
                if (last && err_latch == ERR_NONE) begin
                    if (dec != DEC_ACTION || digit_sh != 0) begin
                        raise_err(ERR_TRUNC);
                    end else if (out_pos != 33'(tgt_size)) begin
                        raise_err(ERR_SIZE);
                    end
                end
            end
            if (have || last || err_latch != err_before) begin
                r.err      = err_latch;
                r.finished = last;
                expected_cmds.push_back(r);
            end
            if (last) begin
                clear_stream();
            end
        endfunction

        function void field_check(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, seen);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_cmd;
            if (expected_cmds.size() == 0) begin
                $error("result with no request waiting: command_kind %0d", got.kind);
                failures++;
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            checked++;
            if (exp_cmd.finished && exp_cmd.err != ERR_NONE) begin
                error_ends++;
            end
            field_check("command_kind", 64'(exp_cmd.kind), 64'(got.kind));
            field_check("from_address", 64'(exp_cmd.from_addr), 64'(got.from_addr));
            field_check("to_address", 64'(exp_cmd.to_addr), 64'(got.to_addr));
            field_check("copy_length", 64'(exp_cmd.length), 64'(got.length));
            field_check("literal_value", 64'(exp_cmd.literal), 64'(got.literal));
            field_check("error_code", 64'(exp_cmd.err), 64'(got.err));
            field_check("finished", 64'(exp_cmd.finished), 64'(got.finished));
        endfunction

        function void close_out();
            if (expected_cmds.size() != 0) begin
                $error("%0d expected results never arrived", expected_cmds.size());
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_patch_byte = '0;
    logic        i_stream_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_command_kind;
    logic [31:0] o_from_address;
    logic [31:0] o_to_address;
    logic [32:0] o_copy_length;
    logic [7:0]  o_literal_value;
    logic [2:0]  o_error_code;
    logic        o_finished;

    command_scoreboard sb = new();
    t_result     seen_cmd;
    logic [7:0]  stream_q[$];
    int          reqs_sent = 0;
    int          streams_sent = 0;
    int          settings_used = 0;
    int          in_idle_pct = 17;
    int          out_idle_pct = 59;
    logic [31:0] src_set[NUM_SETTINGS];
    logic [31:0] tgt_set[NUM_SETTINGS];

    bps_patch_action_decoder_top #(
        .ADDR_BITS(ADDR_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_patch_byte   (i_patch_byte),
        .i_stream_end   (i_stream_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command_kind (o_command_kind),
        .o_from_address (o_from_address),
        .o_to_address   (o_to_address),
        .o_copy_length  (o_copy_length),
        .o_literal_value(o_literal_value),
        .o_error_code   (o_error_code),
        .o_finished     (o_finished)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_patch_byte, i_stream_end);
            end
            if (o_out_valid && !i_out_stall) begin
                seen_cmd.kind      = t_cmd'(o_command_kind);
                seen_cmd.from_addr = o_from_address;
                seen_cmd.to_addr   = o_to_address;
                seen_cmd.length    = o_copy_length;
                seen_cmd.literal   = o_literal_value;
                seen_cmd.err       = t_err'(o_error_code);
                seen_cmd.finished  = o_finished;
                sb.check_result(seen_cmd);
            end
        end
    end

    task automatic send_req(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_patch_byte <= b;
        i_stream_end <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        reqs_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) begin
            send_req(stream_q[i], i == stream_q.size() - 1);
        end
        streams_sent++;
        stream_q.delete();
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] src, input logic [31:0] tgt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        i_cfg_data  <= $urandom;
        @(negedge i_clk);
        i_cfg_index <= REG_SRC_LEN;
        i_cfg_data  <= src;
        sb.write_reg(REG_SRC_LEN, src);
        @(negedge i_clk);
        i_cfg_index <= REG_TGT_SIZE;
        i_cfg_data  <= tgt;
        sb.write_reg(REG_TGT_SIZE, tgt);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic put_number(input logic [63:0] n);
        logic [63:0] rest;
        rest = n;
        while ((rest >> 7) != 0) begin
            stream_q.push_back({1'b0, rest[6:0]});
            rest = (rest >> 7) - 64'd1;
        end
        stream_q.push_back({1'b1, rest[6:0]});
    endtask

    task automatic put_action(input t_action k, input logic [63:0] len);
        put_number(((len - 64'd1) << 2) | 64'(k));
    endtask

    task automatic put_offset(input logic [63:0] to_off, input logic [63:0] from_off);
        logic [63:0] mag;
        logic        neg;
        if (to_off >= from_off) begin
            mag = to_off - from_off;
            neg = 1'b0;
        end else begin
            mag = from_off - to_off;
            neg = 1'b1;
        end
        // sometimes send a zero step as negative zero
        if (mag == 0 && $urandom_range(0, 1)) begin
            neg = 1'b1;
        end
        put_number((mag << 1) | 64'(neg));
    endtask

    task automatic plan_stream(input logic [63:0] goal, input logic [63:0] src);
        logic [63:0] pos;
        logic [63:0] soff;
        logic [63:0] toff;
        logic [63:0] left;
        logic [63:0] len;
        logic [63:0] off;
        int          acts_left;
        bit          last_act;
        t_action     opts[$];
        t_action     k;
        pos       = '0;
        soff      = '0;
        toff      = '0;
        acts_left = $urandom_range(1, 6);
        while (pos < goal) begin
            left     = goal - pos;
            last_act = (acts_left <= 1) || (left == 1);
            if (last_act) begin
                len = left;
            end else begin
                len = 64'($urandom_range(1, (left - 1 > 8) ? 8 : 32'(left - 1)));
            end
            opts.delete();
            if (pos + len <= src) begin
                opts.push_back(ACT_SRC_READ);
            end
            if (len <= 16) begin
                opts.push_back(ACT_TGT_READ);
            end
            if (len <= src) begin
                opts.push_back(ACT_SRC_COPY);
            end
            if (pos > 0) begin
                opts.push_back(ACT_TGT_COPY);
            end
            if (opts.size() == 0) begin
                len = 64'd16;
                k   = ACT_TGT_READ;
            end else begin
                k = opts[$urandom_range(0, opts.size() - 1)];
            end
            put_action(k, len);
            case (k)
                ACT_TGT_READ: begin
                    repeat (len) stream_q.push_back(8'($urandom));
                end
                ACT_SRC_COPY: begin
                    off = 64'($urandom_range(32'(src - len), 0));
                    put_offset(off, soff);
                    soff = off + len;
                end
                ACT_TGT_COPY: begin
                    off = 64'($urandom_range(32'(pos - 1), 0));
                    put_offset(off, toff);
                    toff = off + len;
                end
                default: begin
                end
            endcase
            pos = pos + len;
            acts_left--;
        end
    endtask

    task automatic break_stream();
        int at;
        case ($urandom_range(0, 3))
            0: begin
                if (stream_q.size() > 1) begin
                    at       = $urandom_range(1, stream_q.size() - 1);
                    stream_q = stream_q[0:at-1];
                end
            end
            1: begin
                stream_q.insert($urandom_range(0, stream_q.size()), 8'($urandom));
            end
            2: begin
                at           = $urandom_range(0, stream_q.size() - 1);
                stream_q[at] = stream_q[at] ^ (8'd1 << $urandom_range(0, 7));
            end
            default: begin
                // overrun the address space
                stream_q.delete();
                put_action(ACT_TGT_READ, 64'd1);
                stream_q.push_back(8'($urandom));
                if ($urandom_range(0, 1)) begin
                    put_action(ACT_TGT_COPY, 64'd1 << 36);
                    put_offset(64'd0, 64'd0);
                end else begin
                    put_action(ACT_TGT_READ, (64'd1 << 33) + 64'd1);
                end
                repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic run_setting(input logic [31:0] src, input logic [31:0] tgt,
                               input int quota);
        int          first;
        int          nstreams;
        int          pick;
        logic [63:0] goal;
        wait_idle();
        set_regs(src, tgt);
        first    = reqs_sent;
        nstreams = 0;
        while (reqs_sent - first < quota) begin
            if (nstreams == 3) begin
                wait_idle();
            end
            goal = (tgt == 0) ? 64'($urandom_range(1, 30)) : 64'(tgt);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                plan_stream(goal, 64'(src));
            end else if (pick < 88) begin
                plan_stream(goal, 64'(src));
                break_stream();
            end else begin
                repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
            end
            send_stream();
            nstreams++;
        end
    endtask

    initial begin
        src_set[0] = 32'd0;
        tgt_set[0] = 32'd0;
        src_set[1] = 32'hFFFF_FFFF;
        tgt_set[1] = 32'hFFFF_FFFF;
        src_set[2] = 32'd300;
        tgt_set[2] = 32'd60;
        src_set[3] = 32'd64;
        tgt_set[3] = 32'd200;
        src_set[4] = $urandom_range(5000, 1);
        tgt_set[4] = $urandom_range(400, 1);
        src_set[5] = $urandom;
        tgt_set[5] = $urandom;
        src_set[6] = 32'd1;
        tgt_set[6] = 32'd1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_regs(32'd100, 32'd20);
        // every action kind, literal extremes, negative zero, exact size
        stream_q = '{8'h8C, 8'h85, 8'h00, 8'hFF, 8'h8A, 8'h94, 8'hAB, 8'h81};
        send_stream();
        // end in the middle of a number
        stream_q = '{8'h00};
        send_stream();
        // source read past the source, then a status request
        stream_q = '{8'h1C, 8'h85, 8'hFF};
        send_stream();
        // negative step below zero
        stream_q = '{8'h8A, 8'h8B};
        send_stream();
        // source copy running past the source
        stream_q = '{8'h8A, 8'h44, 8'h80};
        send_stream();
        // saturated action number, offset never arrives
        stream_q = '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF};
        send_stream();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            case (p * 3 / NUM_SETTINGS)
                0: begin
                    in_idle_pct  = 17;
                    out_idle_pct = 59;
                end
                1: begin
                    in_idle_pct  = 59;
                    out_idle_pct = 17;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            run_setting(src_set[p], tgt_set[p], TOTAL_REQS / NUM_SETTINGS);
        end

        wait_idle();
        sb.close_out();
        $display("%0d requests in %0d streams over %0d register settings",
                 reqs_sent, streams_sent, settings_used);
        $display("%0d results checked, %0d streams closed with an error code",
                 sb.checked, sb.error_ends);
        if (sb.failures == 0) begin
            $display("bps_patch_action_decoder_top test passed");
        end else begin
            $display("bps_patch_action_decoder_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("bps_patch_action_decoder_top test failed");
        $finish;
    end

endmodule
